FILE: hdl/cht_pkg.sv
// package for the chained hash table: sizes, codes and payload types
// no dependencies
package cht_pkg;
    localparam int MAX_BUCKETS = 256;
    localparam int ENTRY_COUNT = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int IDX_W = $clog2(ENTRY_COUNT + 1);
    localparam int ENT_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int STEP_W = $clog2(ENTRY_COUNT + 1);
    localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(ENTRY_COUNT);
    localparam int DATA_W = 64 + VALUE_WIDTH + 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_FLUSH  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DUP    = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
        logic [31:0] value;
        logic [15:0] length;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [15:0] found_length;
    } t_rsp;
endpackage

FILE: hdl/cht_if.sv
// valid/ready channel interfaces for requests, responses and configuration
// depends on cht_pkg
interface cht_req_if;
    import cht_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cht_rsp_if;
    import cht_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cht_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/cht_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hdl/chained_hash_table.sv
// chained hash table top level: sequencer over bucket, link and entry memories
// depends on cht_pkg, cht_if and cht_ram
// One request at a time. After reset, and after each flush, a clearing pass over
// max(MAX_BUCKETS, ENTRY_COUNT) addresses rebuilds the bucket heads and the free
// list; requests wait for it. A request then reads its bucket head (S_HEAD,
// S_HWAIT), visits each chain entry in S_ENT and S_CMP (registered link and entry
// memory reads), then writes back in S_WB (and S_FREE for a delete) and responds.
// Response is held in an output register until transferred. bucket_bits is written
// on its own channel, always ready.
module chained_hash_table (
    input  logic i_clk,
    input  logic i_rst_n,
    cht_req_if.sink   i_req,
    cht_rsp_if.source o_rsp,
    cht_cfg_if.sink   i_cfg
);
    import cht_pkg::*;

    localparam int CLR_N = (MAX_BUCKETS > ENTRY_COUNT) ? MAX_BUCKETS : ENTRY_COUNT;
    localparam int CLR_W = $clog2(CLR_N + 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HEAD  = 9'b000000100,
        S_HWAIT = 9'b000001000,
        S_ENT   = 9'b000010000,
        S_CMP   = 9'b000100000,
        S_FREE  = 9'b001000000,
        S_WB    = 9'b010000000,
        S_RSP   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_bbits;
    t_req r_req;
    logic [BKT_W-1:0] r_bkt;
    logic [IDX_W-1:0] r_cur, r_prev, r_free, r_next;
    logic [STEP_W-1:0] r_steps;
    logic [CLR_W-1:0] r_clr;
    t_rsp r_rsp;
    logic r_rsp_v;

    logic hd_we, lk_we;
    logic [BKT_W-1:0] hd_wa, hd_ra;
    logic [IDX_W-1:0] hd_wd, hd_rd, lk_wd, lk_rd;
    logic [ENT_W-1:0] lk_wa, lk_ra, en_ra;
    logic en_we;
    logic [DATA_W-1:0] en_wd, en_rd;

    cht_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BUCKETS)) u_head (
        .i_clk, .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(hd_ra), .o_rdata(hd_rd));
    cht_ram #(.WIDTH(IDX_W), .DEPTH(ENTRY_COUNT)) u_link (
        .i_clk, .i_we(lk_we), .i_waddr(lk_wa), .i_wdata(lk_wd),
        .i_raddr(lk_ra), .o_rdata(lk_rd));
    cht_ram #(.WIDTH(DATA_W), .DEPTH(ENTRY_COUNT)) u_ent (
        .i_clk, .i_we(en_we), .i_waddr(lk_wa), .i_wdata(en_wd),
        .i_raddr(en_ra), .o_rdata(en_rd));

    logic [63:0] masked;
    logic [15:0] bmask;
    logic hit;
    logic [VALUE_WIDTH-1:0] e_val;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_v;
    assign o_rsp.valid = r_rsp_v;
    assign o_rsp.data  = r_rsp;

    assign bmask  = 16'((32'd1 << r_bbits) - 32'd1);
    assign masked = i_req.data.key & {48'd0, bmask};
    assign hit    = en_rd[DATA_W-1 -: 64] == r_req.key;
    assign e_val  = en_rd[DATA_W-65 -: VALUE_WIDTH];
    assign en_wd  = {r_req.key, r_req.value[VALUE_WIDTH-1:0], r_req.length};
    assign hd_ra  = r_bkt;
    assign lk_ra  = (r_state == S_CMP) ? r_free[ENT_W-1:0] : r_cur[ENT_W-1:0];
    assign en_ra  = r_cur[ENT_W-1:0];

    always_comb begin
        hd_we = 1'b0; hd_wa = r_bkt; hd_wd = NIL_IDX;
        lk_we = 1'b0; lk_wa = r_cur[ENT_W-1:0]; lk_wd = NIL_IDX;
        en_we = 1'b0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                hd_we = r_clr < CLR_W'(MAX_BUCKETS);
                hd_wa = BKT_W'(r_clr);
                lk_we = r_clr < CLR_W'(ENTRY_COUNT);
                lk_wa = ENT_W'(r_clr);
                lk_wd = IDX_W'(r_clr) + IDX_W'(1);
                if (r_clr == CLR_W'(CLR_N - 1)) n_state = S_IDLE;
            end
            S_IDLE:  if (i_req.valid && i_req.ready) begin
                n_state = (i_req.data.op == OP_FLUSH) ? S_CLEAR : S_HEAD;
            end
            S_HEAD:  n_state = S_HWAIT;
            S_HWAIT: n_state = S_ENT;
            S_ENT:   n_state = S_CMP;
            S_CMP: begin
                if (r_cur == NIL_IDX || r_steps == STEP_W'(ENTRY_COUNT) || hit) begin
                    n_state = S_WB;
                end else n_state = S_ENT;
            end
            S_WB: begin
                n_state = S_RSP;
                if (r_req.op == OP_INSERT && r_cur == NIL_IDX && r_free != NIL_IDX) begin
                    lk_wa = r_free[ENT_W-1:0];
                    lk_we = 1'b1; lk_wd = r_next;
                    en_we = 1'b1;
                    hd_we = 1'b1; hd_wd = r_free;
                end else if (r_req.op == OP_DELETE && r_cur != NIL_IDX) begin
                    if (r_prev != NIL_IDX) begin
                        lk_we = 1'b1; lk_wa = r_prev[ENT_W-1:0]; lk_wd = r_next;
                    end else begin
                        hd_we = 1'b1; hd_wd = r_next;
                    end
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                lk_we = 1'b1; lk_wd = r_free;
                n_state = S_RSP;
            end
            S_RSP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_bbits <= 4'd8;
            r_free  <= '0;
            r_rsp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) r_bbits <= i_cfg.data;
            if (o_rsp.valid && o_rsp.ready) r_rsp_v <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLR_W'(1);
                    if (n_state == S_IDLE) r_free <= '0;
                end
                S_IDLE: if (i_req.valid && i_req.ready) begin
                    r_req <= i_req.data;
                    r_bkt <= BKT_W'(masked);
                    r_clr <= '0;
                    r_rsp <= '{status: ST_OK, found_value: 32'd0, found_length: 16'd0};
                    if (i_req.data.op == OP_FLUSH) r_rsp_v <= 1'b1;
                end
                S_HEAD: begin
                    r_prev  <= NIL_IDX;
                    r_steps <= '0;
                end
                S_HWAIT: r_cur <= hd_rd;
                S_ENT: ;
                S_CMP: begin
                    if (r_cur == NIL_IDX || r_steps == STEP_W'(ENTRY_COUNT)) begin
                        r_cur <= NIL_IDX;
                        r_next <= hd_rd;
                    end else if (hit) begin
                        r_next <= lk_rd;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= lk_rd;
                        r_steps <= r_steps + STEP_W'(1);
                    end
                end
                S_WB: begin
                    r_rsp_v <= r_req.op != OP_DELETE || r_cur == NIL_IDX;
                    case (r_req.op)
                        OP_INSERT: begin
                            if (r_cur != NIL_IDX) r_rsp.status <= ST_DUP;
                            else if (r_free == NIL_IDX) r_rsp.status <= ST_FULL;
                            else r_free <= lk_rd;
                        end
                        OP_LOOKUP: begin
                            if (r_cur == NIL_IDX) r_rsp.status <= ST_ABSENT;
                            else begin
                                r_rsp.found_value  <= 32'(e_val);
                                r_rsp.found_length <= en_rd[15:0];
                            end
                        end
                        default: if (r_cur == NIL_IDX) r_rsp.status <= ST_ABSENT;
                    endcase
                end
                S_FREE: begin
                    r_free  <= r_cur;
                    r_rsp_v <= 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_rsp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !r_rsp_v) else $error("accept while response pending");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_v && !o_rsp.ready |=> r_rsp_v && $stable(r_rsp))
        else $error("response changed while stalled");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en_we |-> r_state == S_WB && r_free != NIL_IDX)
        else $error("entry write outside insert");
`endif
endmodule

FILE: tb/chained_hash_table_test.sv
// testbench for chained_hash_table: random and directed insert, lookup, delete and flush
// traffic with a behavioral table model checking every response; uses cht_pkg and cht_if
module chained_hash_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cht_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    cht_req_if i_req ();
    cht_rsp_if o_rsp ();
    cht_cfg_if i_cfg ();

    chained_hash_table u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .o_rsp  (o_rsp),
        .i_cfg  (i_cfg)
    );

    // table model
    int          tbl_bits;
    int          tbl_head [MAX_BUCKETS];
    logic [63:0] tbl_key  [ENTRY_COUNT];
    logic [31:0] tbl_val  [ENTRY_COUNT];
    logic [15:0] tbl_len  [ENTRY_COUNT];
    int          tbl_link [ENTRY_COUNT];
    int          tbl_free;

    t_req  pending_reqs [$];
    t_rsp  expected_rsps [$];
    int    errors = 0;
    int    req_wait = 0;
    int    rsp_wait = 0;
    logic [63:0] used_keys [$];

    function automatic void table_clear();
        for (int i = 0; i < MAX_BUCKETS; i++) tbl_head[i] = ENTRY_COUNT;
        for (int i = 0; i < ENTRY_COUNT; i++) tbl_link[i] = i + 1;
        tbl_free = 0;
    endfunction

    function automatic t_rsp table_apply(t_req r);
        t_rsp        o;
        int          b;
        int          cur;
        int          prv;
        int          hit;
        int          steps;
        logic [63:0] msk;
        o = '0;
        o.status = ST_OK;
        if (t_op'(r.op) == OP_FLUSH) begin
            table_clear();
            return o;
        end
        msk = (64'd1 << tbl_bits) - 64'd1;
        b = int'((r.key & msk) % MAX_BUCKETS);
        cur = tbl_head[b];
        prv = ENTRY_COUNT;
        hit = ENTRY_COUNT;
        steps = 0;
        while (cur < ENTRY_COUNT && steps < ENTRY_COUNT) begin
            if (tbl_key[cur] == r.key) begin
                hit = cur;
                break;
            end
            prv = cur;
            cur = tbl_link[cur];
            steps++;
        end
        case (t_op'(r.op))
            OP_INSERT: begin
                if (hit < ENTRY_COUNT) o.status = ST_DUP;
                else if (tbl_free >= ENTRY_COUNT) o.status = ST_FULL;
                else begin
                    hit = tbl_free;
                    tbl_free = tbl_link[hit];
                    tbl_key[hit] = r.key;
                    tbl_val[hit] = r.value;
                    tbl_len[hit] = r.length;
                    tbl_link[hit] = tbl_head[b];
                    tbl_head[b] = hit;
                end
            end
            OP_LOOKUP: begin
                if (hit < ENTRY_COUNT) begin
                    o.found_value = tbl_val[hit];
                    o.found_length = tbl_len[hit];
                end else o.status = ST_ABSENT;
            end
            default: begin
                if (hit < ENTRY_COUNT) begin
                    if (prv < ENTRY_COUNT) tbl_link[prv] = tbl_link[hit];
                    else tbl_head[b] = tbl_link[hit];
                    tbl_link[hit] = tbl_free;
                    tbl_free = hit;
                end else o.status = ST_ABSENT;
            end
        endcase
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req.valid <= 1'b0;
            i_req.data <= '0;
        end else if (i_req.valid && !i_req.ready) begin
        end else begin
            if (i_req.valid) begin
                expected_rsps.push_back(table_apply(i_req.data));
                void'(pending_reqs.pop_front());
                req_wait = $urandom_range(0, 5);
                if ($urandom_range(0, 2) == 0) req_wait = 0;
            end
            if (req_wait > 0) begin
                req_wait--;
                i_req.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req.valid <= 1'b1;
                i_req.data <= pending_reqs[0];
            end else i_req.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rsp.ready <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t unexpected response actual %h", $time, o_rsp.data);
                    errors++;
                end else begin
                    t_rsp exp_rsp;
                    exp_rsp = expected_rsps.pop_front();
                    if (o_rsp.data.status !== exp_rsp.status ||
                        o_rsp.data.found_value !== exp_rsp.found_value ||
                        o_rsp.data.found_length !== exp_rsp.found_length) begin
                        $display("%0t mismatch expected %h actual %h", $time, exp_rsp,
                                 o_rsp.data);
                        errors++;
                    end
                end
                rsp_wait = $urandom_range(0, 5);
                if ($urandom_range(0, 2) == 0) rsp_wait = 0;
            end
            if (rsp_wait > 0) begin
                rsp_wait--;
                o_rsp.ready <= 1'b0;
            end else o_rsp.ready <= 1'b1;
        end
    end

    function automatic t_req make_req(t_op op, logic [63:0] key, logic [31:0] val,
                                      logic [15:0] len);
        t_req r;
        r.op = op;
        r.key = key;
        r.value = val;
        r.length = len;
        return r;
    endfunction

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) k = k & 64'h3ff;
        if (used_keys.size() > 0 && $urandom_range(0, 1) == 1)
            k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        return k;
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || i_req.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_bits(int bits);
        i_cfg.valid <= 1'b1;
        i_cfg.data <= 4'(bits);
        @(posedge i_clk);
        while (!i_cfg.ready) @(posedge i_clk);
        i_cfg.valid <= 1'b0;
        tbl_bits = bits;
    endtask

    task automatic random_phase(int count);
        t_req        r;
        int          sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            r = make_req(sel < 45 ? OP_INSERT : sel < 75 ? OP_LOOKUP :
                         sel < 99 ? OP_DELETE : OP_FLUSH,
                         rand_key(), $urandom, 16'($urandom));
            if (t_op'(r.op) == OP_INSERT) used_keys.push_back(r.key);
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        i_cfg.valid = 1'b0;
        i_cfg.data = '0;
        tbl_bits = 8;
        table_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        pending_reqs.push_back(make_req(OP_LOOKUP, 64'h0, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_INSERT, 64'h0, 32'hffff_ffff, 16'hffff));
        pending_reqs.push_back(make_req(OP_INSERT, 64'hffff_ffff_ffff_ffff, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_INSERT, 64'h100, 32'h1234_5678, 16'h55aa));
        pending_reqs.push_back(make_req(OP_INSERT, 64'h0, 32'd1, 16'd1));
        pending_reqs.push_back(make_req(OP_LOOKUP, 64'h0, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 64'hffff_ffff_ffff_ffff, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 64'h100, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_DELETE, 64'h0, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_DELETE, 64'h0, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 64'h100, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_FLUSH, 64'h0, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 64'h100, 32'd0, 16'd0));
        drain();

        // fill the pool, then full and duplicate-on-full
        set_bits(0);
        for (int i = 0; i < ENTRY_COUNT + 2; i++)
            pending_reqs.push_back(make_req(OP_INSERT, 64'(i * 3), $urandom, 16'($urandom)));
        pending_reqs.push_back(make_req(OP_INSERT, 64'd3, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_DELETE, 64'd30, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_INSERT, 64'hdead, 32'd7, 16'd7));
        pending_reqs.push_back(make_req(OP_LOOKUP, 64'hdead, 32'd0, 16'd0));
        pending_reqs.push_back(make_req(OP_FLUSH, 64'h0, 32'd0, 16'd0));
        drain();

        set_bits(15);
        random_phase(20);
        drain();
        set_bits(2);
        random_phase(20);
        drain();
        set_bits(9);
        random_phase(20);
        drain();
        set_bits(8);
        random_phase(20);
        drain();
        set_bits(0);
        random_phase(10);
        drain();

        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #30000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
